// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and constants for the bounded deque engine.
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 5;

   typedef enum logic [2:0] {
      MODE_INS_FRONT      = 3'd0,
      MODE_INS_BACK       = 3'd1,
      MODE_DUMP_FWD       = 3'd2,
      MODE_DUMP_BWD       = 3'd3,
      MODE_INS_BEFORE_END = 3'd4,
      MODE_RM_BACK        = 3'd5,
      MODE_RM_SECOND_LAST = 3'd6,
      MODE_RM_FRONT       = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_FEW  = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef struct packed {
      mode_type                   mode;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  element;
      logic                       has_element;
      logic                       last;
      status_type                 status;
      logic [COUNT_W-1:0]         count;
   } rsp_type;

endpackage

// ===== hw/rtl/bdq_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
`timescale 1ns / 1ps

module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when the same entry is written
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bounded_deque_engine.sv =====
// Bounded double-ended queue of signed values kept in a ring RAM.
`timescale 1ns / 1ps

//  channel | ports                          | beat carries
//  --------+--------------------------------+------------------------------------
//  request | req_valid, req_ready, req_data | one operation: mode, value
//  result  | rsp_valid, rsp_ready, rsp_data | element, has_element, last,
//          |                                |   status, count
//
//  Steps: insert/remove at either end and every rejected or ignored op end in
//  the accept cycle. Insert-before-last and remove-second-to-last add an ST_MOVE
//  step: the ring RAM has one read port with registered read data, so the last
//  element is read, then written back one slot over. A dump of n elements runs
//  the accept cycle, then a RAM read (ST_DREAD) and a result beat (ST_DDATA)
//  per element; an empty dump answers in the accept cycle.
//  Reset clears front pointer, count and control; RAM contents need no clear
//  since only live entries are ever read.
//  Stalls: a pending result beat blocks new requests; while rsp_ready is low
//  the engine holds its place and the RAM read data stays put.

module bounded_deque_engine import bdq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,  // take a request
      ST_MOVE  = 4'b0010,  // write back the element read in the accept cycle
      ST_DREAD = 4'b0100,  // issue dump read
      ST_DDATA = 4'b1000   // dump data ready, send beat
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] tgt_ff, tgt_in;
   mode_type      op_ff, op_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   logic          out_free;
   logic          full;
   logic          emit;
   logic          dump_last;
   logic [CW-1:0] pos;
   rsp_type       res;

   // ring index of logical position k (k below DEPTH)
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] k);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(k);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   bdq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign full      = (cnt_ff == CW'(DEPTH));
   assign dump_last = (CW'(idx_ff) == cnt_ff - CW'(1));
   assign pos       = (op_ff == MODE_DUMP_FWD) ? CW'(idx_ff)
                                               : cnt_ff - CW'(1) - CW'(idx_ff);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      tgt_in       = tgt_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      emit         = 1'b0;
      res          = '0;
      res.last     = 1'b1;
      res.status   = STAT_DONE;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_data.mode;
               case (req_data.mode)
                  MODE_INS_FRONT: begin
                     emit = 1'b1;
                     if (full) begin
                        res.status = STAT_FULL;
                     end else begin
                        front_in = (front_ff == '0) ? AW'(DEPTH - 1)
                                                    : front_ff - AW'(1);
                        wr_en    = 1'b1;
                        wr_addr  = front_in;
                        wr_data  = req_data.value;
                        cnt_in   = cnt_ff + CW'(1);
                     end
                  end
                  MODE_INS_BACK: begin
                     emit = 1'b1;
                     if (full) begin
                        res.status = STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_of(front_ff, cnt_ff);
                        wr_data = req_data.value;
                        cnt_in  = cnt_ff + CW'(1);
                     end
                  end
                  MODE_DUMP_FWD, MODE_DUMP_BWD: begin
                     if (cnt_ff == '0) begin
                        emit = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_DREAD;
                     end
                  end
                  MODE_INS_BEFORE_END: begin
                     if (cnt_ff == '0) begin
                        emit       = 1'b1;
                        res.status = STAT_FEW;
                     end else if (full) begin
                        emit       = 1'b1;
                        res.status = STAT_FULL;
                     end else begin
                        // read old last and overwrite it with the new value
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(front_ff, cnt_ff - CW'(1));
                        wr_en    = 1'b1;
                        wr_addr  = rd_addr;
                        wr_data  = req_data.value;
                        tgt_in   = slot_of(front_ff, cnt_ff);
                        state_in = ST_MOVE;
                     end
                  end
                  MODE_RM_BACK: begin
                     emit = 1'b1;
                     if (cnt_ff == '0) begin
                        res.status = STAT_FEW;
                     end else begin
                        cnt_in = cnt_ff - CW'(1);
                     end
                  end
                  MODE_RM_SECOND_LAST: begin
                     if (cnt_ff < CW'(2)) begin
                        emit       = 1'b1;
                        res.status = STAT_FEW;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(front_ff, cnt_ff - CW'(1));
                        tgt_in   = slot_of(front_ff, cnt_ff - CW'(2));
                        state_in = ST_MOVE;
                     end
                  end
                  MODE_RM_FRONT: begin
                     emit = 1'b1;
                     if (cnt_ff == '0) begin
                        res.status = STAT_FEW;
                     end else begin
                        front_in = slot_of(front_ff, CW'(1));
                        cnt_in   = cnt_ff - CW'(1);
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_MOVE: begin
            if (out_free) begin
               wr_en    = 1'b1;
               wr_addr  = tgt_ff;
               wr_data  = rd_data;
               cnt_in   = (op_ff == MODE_INS_BEFORE_END) ? cnt_ff + CW'(1)
                                                         : cnt_ff - CW'(1);
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DREAD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(front_ff, pos);
            state_in = ST_DDATA;
         end
         ST_DDATA: begin
            if (out_free) begin
               emit            = 1'b1;
               res.element     = rd_data;
               res.has_element = 1'b1;
               res.last        = dump_last;
               if (dump_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_DREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
         rsp_in.count = COUNT_W'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupancy never passes capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("element count above capacity");

   // a dump leaves the count untouched
   a_dump_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DREAD || state_ff == ST_DDATA) |=> $stable(cnt_ff))
      else $error("count changed during dump");

   // dump index stays inside the live elements
   a_dump_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DREAD || state_ff == ST_DDATA) |-> CW'(idx_ff) < cnt_ff)
      else $error("dump index beyond count");

   // no RAM write while dumping
   a_dump_nowr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DREAD || state_ff == ST_DDATA) |-> !wr_en)
      else $error("ring written during dump");

   // a move always leaves through a result beat
   a_move_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("move finished without result");

endmodule

// ===== bench/bounded_deque_engine_tb.sv =====
// Self-checking testbench for the bounded deque engine: directed table, then random traffic.
`timescale 1ns / 1ps

module bounded_deque_engine_tb import bdq_pkg::*;;

   localparam int DEPTH            = DEPTH_DEFAULT;
   localparam int RESET_CYCLES     = 11;
   localparam int RANDOM_OPS       = 376;   // random requests after the directed table
   localparam int HOLD_AFTER_BEATS = 60;    // start of the long receiver hold-off
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 2 * DEPTH + 8;
   localparam int REPORT_LIMIT     = 10;
   localparam bit FROM_MODEL       = 1'b0;
   localparam bit FIXED            = 1'b1;

   typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED} episode_type;

   // One directed row: the op, and a typed-in result where it is obvious.
   typedef struct packed {
      req_type op;
      bit      typed;
      rsp_type beat;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   always #6 clock = ~clock;

   bounded_deque_engine #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Shadow deque: ring copy, head index and fill level, updated on every
   // accepted request beat. Expected result beats queue up in order.
   // ---------------------------------------------------------------------
   logic signed [VALUE_W-1:0] ring_copy [DEPTH];
   int unsigned head_pos   = 0;
   int unsigned fill_level = 0;
   rsp_type     expected_beats [$];

   int unsigned ops_sent       = 0;
   int unsigned done_ops       = 0;
   int unsigned full_rejects   = 0;
   int unsigned few_ignores    = 0;
   int unsigned dump_beats     = 0;
   int unsigned checked_beats  = 0;
   int unsigned mismatch_count = 0;
   int unsigned burst_left     = 0;

   function automatic int unsigned ring_slot(int unsigned k);
      return (head_pos + k) % DEPTH;
   endfunction

   function automatic void deque_apply(req_type op);
      rsp_type     beat;
      status_type  st;
      int unsigned n;
      bit          fwd;
      beat = '0;
      st   = STAT_DONE;
      n    = fill_level;
      fwd  = (op.mode == MODE_DUMP_FWD);

      // Dumps: one beat per element in walk order, or one empty beat.
      if (op.mode == MODE_DUMP_FWD || op.mode == MODE_DUMP_BWD) begin
         done_ops++;
         if (n == 0) begin
            beat.last = 1'b1;
            expected_beats.push_back(beat);
            return;
         end
         for (int unsigned i = 0; i < n; i++) begin
            beat.element     = ring_copy[ring_slot(fwd ? i : n - 1 - i)];
            beat.has_element = 1'b1;
            beat.last        = (i == n - 1);
            beat.status      = STAT_DONE;
            beat.count       = COUNT_W'(n);
            expected_beats.push_back(beat);
         end
         dump_beats += n;
         return;
      end

      case (op.mode)
         MODE_INS_FRONT: begin
            if (n >= DEPTH) st = STAT_FULL;
            else begin
               head_pos = (head_pos + DEPTH - 1) % DEPTH;
               ring_copy[head_pos] = op.value;
               fill_level++;
            end
         end
         MODE_INS_BACK: begin
            if (n >= DEPTH) st = STAT_FULL;
            else begin
               ring_copy[ring_slot(n)] = op.value;
               fill_level++;
            end
         end
         MODE_INS_BEFORE_END: begin
            // with one element this lands at the front
            if (n == 0) st = STAT_FEW;
            else if (n >= DEPTH) st = STAT_FULL;
            else begin
               ring_copy[ring_slot(n)]     = ring_copy[ring_slot(n - 1)];
               ring_copy[ring_slot(n - 1)] = op.value;
               fill_level++;
            end
         end
         MODE_RM_BACK: begin
            if (n == 0) st = STAT_FEW;
            else fill_level--;
         end
         MODE_RM_SECOND_LAST: begin
            // with two elements this drops the front
            if (n < 2) st = STAT_FEW;
            else begin
               ring_copy[ring_slot(n - 2)] = ring_copy[ring_slot(n - 1)];
               fill_level--;
            end
         end
         default: begin
            if (n == 0) st = STAT_FEW;
            else begin
               head_pos = ring_slot(1);
               fill_level--;
            end
         end
      endcase

      if (st == STAT_DONE) done_ops++;
      else if (st == STAT_FULL) full_rejects++;
      else few_ignores++;

      beat.last   = 1'b1;
      beat.status = st;
      beat.count  = COUNT_W'(fill_level);
      expected_beats.push_back(beat);
   endfunction

   function automatic void check_result_beat(rsp_type got);
      rsp_type want;
      checked_beats++;
      if (expected_beats.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result beat with nothing expected: elem=%0d has=%0b last=%0b %s",
                     $realtime, got.element, got.has_element, got.last,
                     $sformatf("st=%0d cnt=%0d", got.status, got.count));
         return;
      end
      want = expected_beats.pop_front();
      if (got.element !== want.element || got.has_element !== want.has_element ||
          got.last !== want.last || got.status !== want.status || got.count !== want.count) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch, expected elem=%0d has=%0b last=%0b st=%0d cnt=%0d",
                     $realtime, want.element, want.has_element, want.last, want.status,
                     want.count);
            $display("%0t:           actual   elem=%0d has=%0b last=%0b st=%0d cnt=%0d",
                     $realtime, got.element, got.has_element, got.last, got.status, got.count);
         end
      end
   endfunction

   function automatic stim_row_type mk_row(mode_type m, logic signed [VALUE_W-1:0] v,
                                           bit typed, status_type st, int cnt);
      stim_row_type r;
      r.op.mode        = m;
      r.op.value       = v;
      r.typed          = typed;
      r.beat           = '0;
      r.beat.last      = 1'b1;
      r.beat.status    = st;
      r.beat.count     = COUNT_W'(cnt);
      return r;
   endfunction

   // Offer one request beat, hold it until taken, then update the shadow
   // deque. Bursts end in a random gap with valid low.
   task automatic offer_op(input req_type op, input bit typed, input rsp_type typed_beat);
      req_data  <= op;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deque_apply(op);
      if (typed) begin
         void'(expected_beats.pop_back());
         expected_beats.push_back(typed_beat);
      end
      ops_sent++;
      if (burst_left > 0) burst_left--;
      else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 24);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side: reset, directed table, then random episodes.
   // ---------------------------------------------------------------------
   initial begin : request_source
      stim_row_type plan [$];
      req_type      op;
      rsp_type      no_beat;
      mode_type     insert_set [3];
      mode_type     remove_set [3];
      episode_type  episode;
      int unsigned  episode_left;
      int unsigned  random_base;
      int unsigned  roll;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      no_beat   = '0;
      insert_set = '{MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_BEFORE_END};
      remove_set = '{MODE_RM_BACK, MODE_RM_SECOND_LAST, MODE_RM_FRONT};
      episode      = EP_MIXED;
      episode_left = 0;

      // Empty-store cases first, then the one- and two-element corners,
      // then a short mixed walk back down to empty. The first front insert
      // wraps the head around the ring. Full-store rejects come from the
      // fill episodes of the random part.
      plan = '{
         mk_row(MODE_DUMP_FWD,       32'sh0000_0000, FIXED,      STAT_DONE, 0),
         mk_row(MODE_DUMP_BWD,       32'sh7fff_ffff, FIXED,      STAT_DONE, 0),
         mk_row(MODE_RM_BACK,        32'sh1234_5678, FIXED,      STAT_FEW,  0),
         mk_row(MODE_RM_SECOND_LAST, 32'sh1234_5678, FIXED,      STAT_FEW,  0),
         mk_row(MODE_RM_FRONT,       32'sh1234_5678, FIXED,      STAT_FEW,  0),
         mk_row(MODE_INS_BEFORE_END, 32'sh0bad_cafe, FIXED,      STAT_FEW,  0),
         mk_row(MODE_INS_FRONT,      32'sh8000_0000, FIXED,      STAT_DONE, 1),
         mk_row(MODE_RM_SECOND_LAST, 32'sh0000_0000, FIXED,      STAT_FEW,  1),
         mk_row(MODE_INS_BEFORE_END, 32'sh7fff_ffff, FIXED,      STAT_DONE, 2),
         mk_row(MODE_DUMP_FWD,       32'sh0000_0000, FROM_MODEL, STAT_DONE, 0),
         mk_row(MODE_RM_SECOND_LAST, 32'sh0000_0000, FIXED,      STAT_DONE, 1),
         mk_row(MODE_DUMP_BWD,       32'sh0000_0000, FROM_MODEL, STAT_DONE, 0),
         mk_row(MODE_INS_BACK,       -32'sd1,        FIXED,      STAT_DONE, 2),
         mk_row(MODE_INS_BACK,       32'sh0000_0000, FIXED,      STAT_DONE, 3),
         mk_row(MODE_INS_BEFORE_END, 32'sh5555_aaaa, FIXED,      STAT_DONE, 4),
         mk_row(MODE_INS_FRONT,      32'sh0000_0001, FIXED,      STAT_DONE, 5),
         mk_row(MODE_DUMP_FWD,       32'shffff_ffff, FROM_MODEL, STAT_DONE, 0),
         mk_row(MODE_RM_SECOND_LAST, 32'sh0000_0000, FIXED,      STAT_DONE, 4),
         mk_row(MODE_RM_BACK,        32'sh0000_0000, FIXED,      STAT_DONE, 3),
         mk_row(MODE_RM_FRONT,       32'sh0000_0000, FIXED,      STAT_DONE, 2),
         mk_row(MODE_DUMP_BWD,       32'sh0000_0000, FROM_MODEL, STAT_DONE, 0),
         mk_row(MODE_RM_FRONT,       32'sh0000_0000, FIXED,      STAT_DONE, 1),
         mk_row(MODE_RM_BACK,        32'sh0000_0000, FIXED,      STAT_DONE, 0),
         mk_row(MODE_DUMP_FWD,       32'sh0000_0000, FIXED,      STAT_DONE, 0)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) offer_op(plan[i].op, plan[i].typed, plan[i].beat);

      // Random part in episodes: fill runs push the deque to full and past
      // it, drain runs empty it and keep removing, mixed runs are uniform.
      random_base = ops_sent;
      while (ops_sent - random_base < RANDOM_OPS) begin
         if (episode_left == 0) begin
            episode      = episode_type'($urandom_range(0, 2));
            episode_left = $urandom_range(8, 40);
         end
         episode_left--;
         roll = $urandom_range(0, 99);
         case (episode)
            EP_FILL: begin
               if (roll < 75) op.mode = insert_set[$urandom_range(0, 2)];
               else if (roll < 85) op.mode = roll[0] ? MODE_DUMP_FWD : MODE_DUMP_BWD;
               else op.mode = remove_set[$urandom_range(0, 2)];
            end
            EP_DRAIN: begin
               if (roll < 75) op.mode = remove_set[$urandom_range(0, 2)];
               else if (roll < 85) op.mode = roll[0] ? MODE_DUMP_FWD : MODE_DUMP_BWD;
               else op.mode = insert_set[$urandom_range(0, 2)];
            end
            default: op.mode = mode_type'($urandom_range(0, 7));
         endcase
         // value is driven on every op, even where it is ignored
         case ($urandom_range(0, 11))
            0:       op.value = 32'sh8000_0000;
            1:       op.value = 32'sh7fff_ffff;
            2:       op.value = '0;
            3:       op.value = '1;
            default: op.value = $urandom;
         endcase
         offer_op(op, FROM_MODEL, no_beat);
      end
      req_valid <= 1'b0;

      // Drain: every expected beat back, then a quiet window for strays.
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, %0d took effect; %0d result beats checked, %0d from dumps.",
               ops_sent, done_ops, checked_beats, dump_beats);
      $display("Full-store rejects: %0d, too-few ignores: %0d, mismatches: %0d.",
               full_rejects, few_ignores, mismatch_count);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: ready follows an 8-bit pattern that is redrawn as the tick
   // counter runs (sometimes all ones). Once, after HOLD_AFTER_BEATS beats, ready is
   // held low for a long stretch so the engine backs up and drops req_ready.
   // ---------------------------------------------------------------------
   initial begin : result_sink
      logic [7:0]  ready_pattern;
      int unsigned tick;
      bit          held_off;

      rsp_ready    <= 1'b0;
      ready_pattern = 8'hff;
      tick          = 0;
      held_off      = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_result_beat(rsp_data);
         tick++;
         if (tick % 32 == 0) begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
            if (ready_pattern == 8'h00) ready_pattern = 8'h01;
         end
         if (!held_off && checked_beats >= HOLD_AFTER_BEATS) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ready_pattern[tick % 8];
         end
      end
   end

   // Watchdog, several times the slowest legal run.
   initial begin : watchdog
      #6_000_000;
      $display("Timeout: %0d result beats still expected", expected_beats.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
